>>> rtl/tbd_pkg.sv
// Shared types and constants of the text block deframer.
package tbd_pkg;

	// Deframing mode, one-hot.
	typedef enum logic [4:0] {
		MODE_KEY    = 5'b00001,
		MODE_COPY   = 5'b00010,
		MODE_MARK   = 5'b00100,
		MODE_ENDED  = 5'b01000,
		MODE_LOCKED = 5'b10000
	} mode_t;

	// Status codes carried with each result beat.
	localparam logic [1:0] STATUS_DATA = 2'd0;
	localparam logic [1:0] STATUS_PASS = 2'd1;
	localparam logic [1:0] STATUS_FAIL = 2'd2;

	// Key check: (base + 13*a + 23*b + 31*c) mod 2^16 must equal d.
	localparam logic [15:0] KEY_BASE  = 16'he48d;
	localparam logic [15:0] KEY_MUL_A = 16'd13;
	localparam logic [15:0] KEY_MUL_B = 16'd23;
	localparam logic [15:0] KEY_MUL_C = 16'd31;

	localparam logic [7:0] MARKER_RESET = 8'd3;

	localparam int unsigned BLOCK_BYTES = 8;

	typedef struct packed {
		logic [63:0] text_bytes;
		logic [3:0]  byte_count;
		logic [1:0]  status;
		logic        text_ended;
	} result_t;

endpackage

>>> rtl/tbd_if.sv
// Valid/ready channel interfaces for cipher blocks and recovered text.
interface tbd_block_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_left;
	logic [31:0] block_right;

	modport source (output valid, output block_left, output block_right, input ready);
	modport sink (input valid, input block_left, input block_right, output ready);
endinterface

interface tbd_text_if;
	logic        valid;
	logic        ready;
	logic [63:0] text_bytes;
	logic [3:0]  byte_count;
	logic [1:0]  status;
	logic        text_ended;

	modport source (output valid, output text_bytes, output byte_count, output status,
		output text_ended, input ready);
	modport sink (input valid, input text_bytes, input byte_count, input status,
		input text_ended, output ready);
endinterface

>>> rtl/tbd_scan.sv
// Combinational key check and eight-byte marker scan for one block.
module tbd_scan
	import tbd_pkg::*;
(
	input  mode_t       mode,
	input  logic [7:0]  marker,
	input  logic [31:0] block_left,
	input  logic [31:0] block_right,
	output mode_t       mode_next,
	output result_t     result
);

	logic [15:0] key_sum;
	logic        key_ok;

	// The sum wraps at 16 bits, which the assignment width gives for free.
	assign key_sum = KEY_BASE + block_right[15:0] * KEY_MUL_A
		+ block_right[31:16] * KEY_MUL_B + block_left[15:0] * KEY_MUL_C;
	assign key_ok = (key_sum == block_left[31:16]);

	always_comb begin
		logic [63:0] word;
		logic [63:0] packed_bytes;
		logic [3:0]  cnt;
		logic [1:0]  stat;
		logic [7:0]  cur;
		logic        emit;
		mode_t       m;

		word         = {block_right, block_left};
		packed_bytes = '0;
		cnt          = '0;
		stat         = STATUS_DATA;
		cur          = '0;
		emit         = 1'b0;
		m            = mode;

		unique case (mode)
			MODE_KEY: begin
				if (key_ok) begin
					m    = MODE_COPY;
					stat = STATUS_PASS;
				end else begin
					m    = MODE_LOCKED;
					stat = STATUS_FAIL;
				end
			end
			MODE_LOCKED: begin
				stat = STATUS_FAIL;
			end
			MODE_COPY, MODE_MARK, MODE_ENDED: begin
				for (int k = 0; k < BLOCK_BYTES; k++) begin
					cur  = word[k*8 +: 8];
					emit = 1'b0;
					if (m == MODE_COPY) begin
						if (cur == marker)
							m = MODE_MARK;
						else
							emit = 1'b1;
					end else if (m == MODE_MARK) begin
						if (cur == marker) begin
							m    = MODE_COPY;
							emit = 1'b1;
						end else begin
							m = MODE_ENDED;
						end
					end
					if (emit && !cnt[3]) begin
						packed_bytes[{cnt[2:0], 3'b000} +: 8] = cur;
						cnt = cnt + 4'd1;
					end
				end
			end
			default: begin
				m    = MODE_LOCKED;
				stat = STATUS_FAIL;
			end
		endcase

		mode_next         = m;
		result.text_bytes = packed_bytes;
		result.byte_count = cnt;
		result.status     = stat;
		result.text_ended = (m == MODE_ENDED);
	end

endmodule

>>> rtl/text_block_deframer.sv
// Top level of the text block deframer: input register, scan logic and result register.
//
//   channel   direction  handshake          payload
//   blocks    in         valid/ready        block_left[31:0], block_right[31:0]
//   text      out        valid/ready        text_bytes[63:0], byte_count[3:0],
//                                           status[1:0], text_ended
//   cfg       in         cfg_we (no wait)   cfg_wdata[7:0] -> end_marker
//
// A block passes through the input register and then the result register on its way
// to its result beat. One block is accepted every cycle while the text side keeps
// taking beats; the scan over eight bytes is combinational, between those registers.
// Reset empties both registers, returns the mode to awaiting the key check block
// and sets the end marker to 3.
// When the text side stalls, the result register holds and the input register
// still takes one more block before ready falls.
module text_block_deframer
	import tbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tbd_block_if.sink  blocks,
	tbd_text_if.source text,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	// Input register stage.
	logic        valid_s1;
	logic [31:0] left_s1;
	logic [31:0] right_s1;

	// Result register stage.
	logic        valid_s2;
	result_t     result_s2;

	logic [7:0]  marker_q;
	mode_t       mode_q;
	mode_t       mode_next;
	result_t     result_next;

	logic        out_free;
	logic        advance;

	// The result register can take a new beat when it is empty or being drained.
	assign out_free     = !valid_s2 || text.ready;
	assign advance      = valid_s1 && out_free;
	assign blocks.ready = !valid_s1 || advance;

	// End marker register. The user must write only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_we) begin
			marker_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (blocks.ready) begin
			valid_s1 <= blocks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (blocks.valid && blocks.ready) begin
			left_s1  <= blocks.block_left;
			right_s1 <= blocks.block_right;
		end
	end

	// The mode moves on exactly when a block passes into the result register,
	// so the escape state carries from one block to the next in order.
	tbd_scan u_scan (
		.mode        (mode_q),
		.marker      (marker_q),
		.block_left  (left_s1),
		.block_right (right_s1),
		.mode_next   (mode_next),
		.result      (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_KEY;
			valid_s2 <= 1'b0;
		end else begin
			if (advance)
				mode_q <= mode_next;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result_next;
	end

	assign text.valid      = valid_s2;
	assign text.text_bytes = result_s2.text_bytes;
	assign text.byte_count = result_s2.byte_count;
	assign text.status     = result_s2.status;
	assign text.text_ended = result_s2.text_ended;

	// A failed key check locks the block until reset.
	a_locked_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_LOCKED |=> mode_q == MODE_LOCKED)
		else $error("locked mode was left without reset");

	// Once the text has ended it stays ended.
	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ENDED |=> mode_q == MODE_ENDED)
		else $error("ended mode was left without reset");

	// A failure beat carries no text and no end flag.
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.status == STATUS_FAIL |->
			text.byte_count == 4'd0 && !text.text_ended)
		else $error("failure beat carries text");

	// Never more bytes than one block holds.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> text.byte_count <= 4'd8)
		else $error("byte count above eight");

	// With both registers full and the text side stalled, no block is taken.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && text.valid && !text.ready |-> !blocks.ready)
		else $error("block accepted while both stages are full and stalled");

endmodule
